@@ rtl/dtf_pkg.sv @@
package dtf_pkg;

	// Result field widths
	localparam int VALUE_W = 48;
	localparam int MAG_W   = VALUE_W - 1;
	localparam logic [MAG_W-1:0] MAX_MAG = {MAG_W{1'b1}};

	// Divisor width: 10^18 is the largest power of ten in use and fits 60 bits
	localparam int POW_W   = 60;
	localparam int POW_IDX = 5;

	// Status codes
	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_NO_ARG = 2'd1;
	localparam logic [1:0] STAT_DIGIT  = 2'd2;
	localparam logic [1:0] STAT_UNEXP  = 2'd3;

	// Character codes
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [7:0] COUNT_MAX = 8'hFF;

	// Divider status towards the sequencer
	typedef struct packed {
		logic             done;
		logic             clamp;
		logic [MAG_W-1:0] mag;
	} dtf_div_res_t;

	function automatic logic [POW_W-1:0] pow10(input logic [POW_IDX-1:0] k);
		logic [POW_W-1:0] p;
		begin
			case (k)
				5'd0:    p = 60'd1;
				5'd1:    p = 60'd10;
				5'd2:    p = 60'd100;
				5'd3:    p = 60'd1000;
				5'd4:    p = 60'd10000;
				5'd5:    p = 60'd100000;
				5'd6:    p = 60'd1000000;
				5'd7:    p = 60'd10000000;
				5'd8:    p = 60'd100000000;
				5'd9:    p = 60'd1000000000;
				5'd10:   p = 60'd10000000000;
				5'd11:   p = 60'd100000000000;
				5'd12:   p = 60'd1000000000000;
				5'd13:   p = 60'd10000000000000;
				5'd14:   p = 60'd100000000000000;
				5'd15:   p = 60'd1000000000000000;
				5'd16:   p = 60'd10000000000000000;
				5'd17:   p = 60'd100000000000000000;
				5'd18:   p = 60'd1000000000000000000;
				default: p = 60'd1;
			endcase
			return p;
		end
	endfunction

endpackage

@@ rtl/dtf_div.sv @@
// Restoring binary long division, one quotient bit per cycle.
// Computes floor(mant * 2^FRAC_BITS / 10^digits), clamped to MAX_MAG.
module dtf_div import dtf_pkg::*; #(
	parameter int MANT_BITS = 60,
	parameter int FRAC_BITS = 16,
	parameter int FD_W      = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [MANT_BITS-1:0] mant,
	input  logic [FD_W-1:0]      digits,
	output dtf_div_res_t         res
);

	localparam int STEPS = MANT_BITS + FRAC_BITS;
	localparam int CNT_W = $clog2(STEPS);

	logic                 busy_q;
	logic                 done_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [MANT_BITS-1:0] dvd_q;
	logic [POW_W-1:0]     div_q;
	logic [POW_W-1:0]     rem_q;
	logic [MAG_W-1:0]     mag_q;
	logic                 clamp_q;

	logic [POW_W:0]       trial;
	logic                 ge;
	logic [POW_W:0]       diff;
	logic                 last;

	assign trial = {rem_q, dvd_q[MANT_BITS-1]};
	assign ge    = (trial >= {1'b0, div_q});
	assign diff  = trial - {1'b0, div_q};
	assign last  = (cnt_q == CNT_W'(STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last)
					busy_q <= 1'b0;
			end
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q   <= mant;
			div_q   <= pow10(POW_IDX'(digits));
			rem_q   <= '0;
			mag_q   <= '0;
			clamp_q <= 1'b0;
		end else if (busy_q) begin
			dvd_q   <= {dvd_q[MANT_BITS-2:0], 1'b0};
			rem_q   <= ge ? diff[POW_W-1:0] : trial[POW_W-1:0];
			mag_q   <= {mag_q[MAG_W-2:0], ge};
			// any quotient bit pushed past the top means overflow
			clamp_q <= clamp_q | mag_q[MAG_W-1];
		end
	end

	assign res.done  = done_q;
	assign res.clamp = clamp_q;
	assign res.mag   = clamp_q ? MAX_MAG : mag_q;

endmodule

@@ rtl/decimal_text_to_fixed_parser_unit.sv @@
// Ordinary characters: one per cycle, accepted back to back while the sequencer is idle.
// Terminator with digits: the bit-serial divider turns the decimal mantissa into fixed
// point, and the result is registered once the output register is free; without digits
// or after integer overflow the divider is skipped and HOLD registers the result.
// Output register decouples the sides: characters keep flowing while a result waits.
// arst_n clears the parser to the whitespace phase and sets end_check to 1.
module decimal_text_to_fixed_parser_unit import dtf_pkg::*; #(
	parameter int MAX_FRAC_DIGITS = 9,
	parameter int FRAC_BITS       = 16,
	parameter int MANT_BITS       = 60
) (
	input  logic                      clk,
	input  logic                      arst_n,
	// character stream
	input  logic [7:0]                char_in,
	input  logic                      in_valid,
	output logic                      in_stall,
	// results
	output logic signed [VALUE_W-1:0] value,
	output logic [1:0]                status,
	output logic [7:0]                consumed,
	output logic                      saturated,
	output logic                      out_valid,
	input  logic                      out_stall,
	// end_check register write
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_data
);

	localparam int FD_W = $clog2(MAX_FRAC_DIGITS + 1);
	localparam logic [MANT_BITS-1:0] MANT_MAX = {MANT_BITS{1'b1}};

	// Sequencer: IDLE takes characters, CONV runs the divider, HOLD waits for
	// the output register to come free.
	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_HOLD = 3'b100
	} state_t;

	// Parse phase; an unknown code behaves as whitespace phase
	typedef enum logic [2:0] {
		PH_WS   = 3'b001,
		PH_INT  = 3'b010,
		PH_FRAC = 3'b100
	} phase_t;

	state_t               state_q;
	phase_t               phase_q;
	logic                 end_check_q;
	logic                 neg_q;
	logic                 seen_q;
	logic                 ovf_q;
	logic [MANT_BITS-1:0] mant_q;
	logic [FD_W-1:0]      fd_q;
	logic [7:0]           count_q;
	logic [1:0]           term_stat_q;

	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] value_q;
	logic [1:0]                status_q;
	logic [7:0]                consumed_q;
	logic                      saturated_q;

	logic                 acc;
	logic                 ph_int, ph_frac, ph_ws;
	logic                 is_space, is_digit, is_sign;
	logic                 take_ws, take_sign, take_point, take_digit, term;
	logic [1:0]           term_stat;
	logic [3:0]           digit;
	logic [MANT_BITS+3:0] mant_x;
	logic [MANT_BITS+3:0] prod;
	logic                 fits;
	logic                 div_start;
	logic                 out_free;
	logic                 load;
	logic [MAG_W-1:0]     mag_sel;
	logic                 clamp_sel;
	logic [VALUE_W-1:0]   mag_ext;
	logic [VALUE_W-1:0]   value_n;
	dtf_div_res_t         div_res;

	// Configuration: always ready; software writes while the block is idle (the block itself does not enforce it)
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			end_check_q <= 1'b1;
		else if (cfg_valid && cfg_ready)
			end_check_q <= cfg_data;
	end

	// ---------------------------------------------------------------------
	// Character classification
	// ---------------------------------------------------------------------
	assign in_stall = (state_q != ST_IDLE);
	assign acc      = in_valid && !in_stall;

	assign ph_int  = (phase_q == PH_INT);
	assign ph_frac = (phase_q == PH_FRAC);
	assign ph_ws   = !ph_int && !ph_frac;

	always_comb begin
		is_space = (char_in inside {[CH_TAB:CH_CR], CH_SPACE});
		is_digit = (char_in inside {[CH_ZERO:CH_NINE]});
		is_sign  = (char_in inside {CH_PLUS, CH_MINUS});
	end

	assign take_ws    = ph_ws && is_space;
	assign take_sign  = ph_ws && is_sign;
	assign take_point = !ph_frac && (char_in == CH_POINT);
	assign take_digit = is_digit;
	assign term       = !(take_ws || take_sign || take_point || take_digit);

	// low nibble of '0'..'9' is the digit value
	assign digit = char_in[3:0];

	// mantissa*10 + digit; overflow when anything spills above MANT_BITS
	assign mant_x = {4'b0000, mant_q};
	assign prod   = (mant_x << 3) + (mant_x << 1) + {{MANT_BITS{1'b0}}, digit};
	assign fits   = (prod[MANT_BITS+3 -: 4] == 4'b0000);

	always_comb begin
		if (!seen_q)
			term_stat = (char_in == CH_NUL) ? STAT_NO_ARG : STAT_DIGIT;
		else if (end_check_q && !is_space && (char_in != CH_NUL))
			term_stat = STAT_UNEXP;
		else
			term_stat = STAT_OK;
	end

	// ---------------------------------------------------------------------
	// Conversion: only a valid, non-overflowed number needs the divider
	// ---------------------------------------------------------------------
	assign div_start = acc && term && seen_q && !ovf_q;

	dtf_div #(
		.MANT_BITS (MANT_BITS),
		.FRAC_BITS (FRAC_BITS),
		.FD_W      (FD_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mant   (mant_q),
		.digits (fd_q),
		.res    (div_res)
	);

	// ---------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------
	assign out_free = !out_valid_q || !out_stall;
	assign load     = (state_q == ST_HOLD) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (acc && term)
						state_q <= div_start ? ST_CONV : ST_HOLD;
				end
				ST_CONV: begin
					if (div_res.done)
						state_q <= ST_HOLD;
				end
				ST_HOLD: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// ---------------------------------------------------------------------
	// Parser state; held through conversion, rearmed on result transfer
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WS;
			neg_q       <= 1'b0;
			seen_q      <= 1'b0;
			ovf_q       <= 1'b0;
			mant_q      <= '0;
			fd_q        <= '0;
			count_q     <= '0;
			term_stat_q <= STAT_OK;
		end else if (load) begin
			phase_q <= PH_WS;
			neg_q   <= 1'b0;
			seen_q  <= 1'b0;
			ovf_q   <= 1'b0;
			mant_q  <= '0;
			fd_q    <= '0;
			count_q <= '0;
		end else if (acc) begin
			if (term) begin
				term_stat_q <= term_stat;
			end else begin
				if (count_q != COUNT_MAX)
					count_q <= count_q + 8'd1;
				if (take_ws) begin
					// whitespace: nothing but the count
				end else if (take_sign) begin
					neg_q   <= (char_in == CH_MINUS);
					phase_q <= PH_INT;
				end else if (take_point) begin
					phase_q <= PH_FRAC;
				end else begin
					seen_q <= 1'b1;
					if (ph_ws)
						phase_q <= PH_INT;
					if (ph_frac) begin
						// surplus or overflowing fraction digits are dropped
						if (!ovf_q && (fd_q < FD_W'(MAX_FRAC_DIGITS)) && fits) begin
							mant_q <= prod[MANT_BITS-1:0];
							fd_q   <= fd_q + FD_W'(1);
						end
					end else if (!ovf_q) begin
						if (fits) begin
							mant_q <= prod[MANT_BITS-1:0];
						end else begin
							mant_q <= MANT_MAX;
							ovf_q  <= 1'b1;
						end
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------------
	always_comb begin
		if (!seen_q) begin
			mag_sel   = '0;
			clamp_sel = 1'b0;
		end else if (ovf_q) begin
			mag_sel   = MAX_MAG;
			clamp_sel = 1'b1;
		end else begin
			mag_sel   = div_res.mag;
			clamp_sel = div_res.clamp;
		end
	end

	assign mag_ext = {1'b0, mag_sel};
	assign value_n = neg_q ? (VALUE_W'(0) - mag_ext) : mag_ext;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			value_q     <= value_n;
			status_q    <= term_stat_q;
			consumed_q  <= count_q;
			saturated_q <= clamp_sel;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;
	assign consumed  = consumed_q;
	assign saturated = saturated_q;

endmodule

@@ rtl/dtf_chk.sv @@
module dtf_chk import dtf_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_stall,
	input logic signed [VALUE_W-1:0] value,
	input logic [1:0]                status,
	input logic                      saturated,
	input logic                      out_valid,
	input logic                      out_stall
);

	localparam logic [VALUE_W-1:0] POS_MAX = {1'b0, MAX_MAG};
	localparam logic [VALUE_W-1:0] NEG_MAX = {1'b1, {(MAG_W-1){1'b0}}, 1'b1};

	// stalled result is held
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(value) && $stable(status))
		else $error("result changed while stalled");

	// clamped result sits at full scale
	a_sat_mag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |-> (value == POS_MAX) || (value == NEG_MAX))
		else $error("saturated result not at full scale");

	// failed parse gives zero and no clamp
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((status == STAT_NO_ARG) || (status == STAT_DIGIT))
		|-> (value == '0) && !saturated)
		else $error("failed parse with non-zero result");

	// a new result only follows a cycle with the input held off
	a_new_after_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without terminator handling");

endmodule

bind decimal_text_to_fixed_parser_unit dtf_chk u_dtf_chk (.*);
